// File: rtl/core/csvt_pkg.sv
// Package for the CSV field tokenizer: parse phases, error codes, register
// indexes, the configuration and result records, and the escape decoder.
// No dependencies.
package csvt_pkg;

  localparam int unsigned LINE_COUNT_BITS_DEF = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ERR_W = 3;
  localparam int unsigned ERR_LINE_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] LF_BYTE = 8'h0A;
  localparam logic [BYTE_W-1:0] BACKSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] SEP_RESET = 8'h2C;
  localparam logic [BYTE_W-1:0] COMMENT_RESET = 8'h23;
  localparam logic [BYTE_W-1:0] QUOTE_RESET = 8'h22;

  localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTE = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE = 3'd0;
  localparam logic [ERR_W-1:0] ERR_JUNK_AFTER_QUOTE = 3'd1;
  localparam logic [ERR_W-1:0] ERR_UNFINISHED_ESCAPE = 3'd2;
  localparam logic [ERR_W-1:0] ERR_BAD_ESCAPE = 3'd3;
  localparam logic [ERR_W-1:0] ERR_UNTERMINATED_QUOTE = 3'd4;

  typedef enum logic [2:0] {
    PH_LINE_START  = 3'd0,
    PH_FIELD_START = 3'd1,
    PH_PLAIN       = 3'd2,
    PH_QUOTED      = 3'd3,
    PH_ESCAPE      = 3'd4,
    PH_AFTER_QUOTE = 3'd5,
    PH_DISCARD     = 3'd6
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] separator_char;
    logic [BYTE_W-1:0] comment_char;
    logic [BYTE_W-1:0] quote_char;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0]     out_byte;
    logic                  byte_valid;
    logic                  field_end;
    logic                  row_end;
    logic [ERR_W-1:0]      error_code;
    logic [ERR_LINE_W-1:0] error_line;
  } res_t;

  typedef struct packed {
    logic              ok;
    logic [BYTE_W-1:0] value;
  } esc_t;

  // Decodes the byte after a backslash; the quote byte always maps to itself.
  function automatic esc_t map_escape(input logic [BYTE_W-1:0] c,
                                      input logic [BYTE_W-1:0] quote);
    esc_t e;
    e.ok = 1'b1;
    e.value = '0;
    if (c == quote) begin
      e.value = quote;
    end else begin
      case (c)
        8'h76:     e.value = 8'h0B;  // v
        8'h74:     e.value = 8'h09;  // t
        8'h72:     e.value = 8'h0D;  // r
        8'h6E:     e.value = 8'h0A;  // n
        8'h66:     e.value = 8'h0C;  // f
        BACKSLASH: e.value = BACKSLASH;
        default:   e.ok = 1'b0;
      endcase
    end
    return e;
  endfunction

endpackage

// File: rtl/core/csvt_if.sv
// Handshake interfaces of the CSV field tokenizer: input, result and
// configuration channels. Depends on csvt_pkg.
interface csvt_in_if;
  logic                      valid;
  logic                      ready;
  logic [csvt_pkg::BYTE_W-1:0] in_byte;
  logic                      end_of_input;
  modport source (output valid, in_byte, end_of_input, input ready);
  modport sink (input valid, in_byte, end_of_input, output ready);
endinterface

interface csvt_out_if;
  logic                          valid;
  logic                          ready;
  logic [csvt_pkg::BYTE_W-1:0]     out_byte;
  logic                          byte_valid;
  logic                          field_end;
  logic                          row_end;
  logic [csvt_pkg::ERR_W-1:0]      error_code;
  logic [csvt_pkg::ERR_LINE_W-1:0] error_line;
  modport source (output valid, out_byte, byte_valid, field_end, row_end, error_code,
                  error_line, input ready);
  modport sink (input valid, out_byte, byte_valid, field_end, row_end, error_code,
                error_line, output ready);
endinterface

interface csvt_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [csvt_pkg::CFG_IDX_W-1:0] index;
  logic [csvt_pkg::BYTE_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/csvt_parser.sv
// Parse step of the CSV field tokenizer: phase and line-count registers and
// the logic that turns one byte into one result. Depends on csvt_pkg.
module csvt_parser #(
  parameter int unsigned LINE_COUNT_BITS = csvt_pkg::LINE_COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_en,
  input  logic [csvt_pkg::BYTE_W-1:0] in_byte,
  input  logic                        end_of_input,
  input  csvt_pkg::cfg_t              cfg,
  output csvt_pkg::res_t              result
);
  import csvt_pkg::*;

  phase_t                     phase_r, phase_nxt;
  logic [LINE_COUNT_BITS-1:0] line_r, line_nxt;
  logic [LINE_COUNT_BITS-1:0] this_line;
  logic [LINE_COUNT_BITS+ERR_LINE_W-1:0] line_ext;
  logic                       eol;
  esc_t                       esc;

  assign eol = end_of_input || (in_byte == LF_BYTE);
  assign this_line = line_r + {{(LINE_COUNT_BITS-1){1'b0}}, 1'b1};
  assign line_ext = {{ERR_LINE_W{1'b0}}, this_line};
  assign esc = map_escape(in_byte, cfg.quote_char);
  assign line_nxt = eol ? this_line : line_r;

  always_comb begin
    phase_nxt = phase_r;
    result = '0;
    case (phase_r)
      PH_LINE_START: begin
        if (eol) begin
          phase_nxt = PH_LINE_START;
        end else if (in_byte == cfg.comment_char) begin
          phase_nxt = PH_DISCARD;
        end else if (in_byte == cfg.quote_char) begin
          phase_nxt = PH_QUOTED;
        end else if (in_byte == cfg.separator_char) begin
          // Empty first field.
          result.field_end = 1'b1;
          phase_nxt = PH_FIELD_START;
        end else begin
          result.out_byte = in_byte;
          result.byte_valid = 1'b1;
          phase_nxt = PH_PLAIN;
        end
      end
      PH_FIELD_START: begin
        if (eol) begin
          result.field_end = 1'b1;
          result.row_end = 1'b1;
          phase_nxt = PH_LINE_START;
        end else if (in_byte == cfg.quote_char) begin
          phase_nxt = PH_QUOTED;
        end else if (in_byte == cfg.separator_char) begin
          result.field_end = 1'b1;
        end else begin
          result.out_byte = in_byte;
          result.byte_valid = 1'b1;
          phase_nxt = PH_PLAIN;
        end
      end
      PH_PLAIN: begin
        if (eol) begin
          result.field_end = 1'b1;
          result.row_end = 1'b1;
          phase_nxt = PH_LINE_START;
        end else if (in_byte == cfg.separator_char) begin
          result.field_end = 1'b1;
          phase_nxt = PH_FIELD_START;
        end else begin
          result.out_byte = in_byte;
          result.byte_valid = 1'b1;
        end
      end
      PH_QUOTED: begin
        if (eol) begin
          result.error_code = ERR_UNTERMINATED_QUOTE;
          phase_nxt = PH_LINE_START;
        end else if (in_byte == cfg.quote_char) begin
          phase_nxt = PH_AFTER_QUOTE;
        end else if (in_byte == BACKSLASH) begin
          phase_nxt = PH_ESCAPE;
        end else begin
          result.out_byte = in_byte;
          result.byte_valid = 1'b1;
        end
      end
      PH_ESCAPE: begin
        if (eol) begin
          result.error_code = ERR_UNFINISHED_ESCAPE;
          phase_nxt = PH_LINE_START;
        end else if (esc.ok) begin
          result.out_byte = esc.value;
          result.byte_valid = 1'b1;
          phase_nxt = PH_QUOTED;
        end else begin
          result.error_code = ERR_BAD_ESCAPE;
          phase_nxt = PH_DISCARD;
        end
      end
      PH_AFTER_QUOTE: begin
        if (eol) begin
          result.field_end = 1'b1;
          result.row_end = 1'b1;
          phase_nxt = PH_LINE_START;
        end else if (in_byte == cfg.separator_char) begin
          result.field_end = 1'b1;
          phase_nxt = PH_FIELD_START;
        end else begin
          result.error_code = ERR_JUNK_AFTER_QUOTE;
          phase_nxt = PH_DISCARD;
        end
      end
      default: begin
        phase_nxt = eol ? PH_LINE_START : PH_DISCARD;
      end
    endcase
    if (result.error_code != ERR_NONE) begin
      result.error_line = line_ext[ERR_LINE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LINE_START;
      line_r <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      line_r <= line_nxt;
    end
  end

endmodule

// File: rtl/core/csv_field_tokenizer_top.sv
// Top level of the CSV field tokenizer: input register, parse step, result
// register and configuration registers. Depends on csvt_pkg, csvt_if and
// csvt_parser.
//
// The block splits a byte stream into CSV fields at a rate of one byte per
// clock while the result side is ready. Every accepted input item yields
// exactly one result item: the byte is captured in an input register, then
// one parse step against the phase register decides the result, which waits
// in the result register until taken. The phase and line-count registers
// are the only loop, so input items may arrive back to back; the input
// register keeps accepting while a finished result is still waiting, and
// stalls only when both registers are full and the result side is not ready.
// A line ends at 0x0A or at an item with end_of_input set (its byte is
// ignored). Empty lines and lines that start with the comment byte produce
// all-zero results. Quoted fields accept backslash escapes (v t r n f,
// backslash and the quote byte). An error result carries the code and the
// line number counted from one, and the rest of that line is discarded.
// The configuration channel is always ready; registers should be written
// only while no item is in flight. A write to an index beyond the quote
// register is accepted and ignored.
module csv_field_tokenizer_top #(
  parameter int unsigned LINE_COUNT_BITS = csvt_pkg::LINE_COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  csvt_in_if.sink     in_ch,
  csvt_out_if.source  out_ch,
  csvt_cfg_if.sink    cfg_ch
);
  import csvt_pkg::*;

  // Input register.
  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_eoi_r;

  // Result register.
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  cfg_t cfg_r, cfg_nxt;
  res_t step_res;
  logic s2_load;
  logic in_acc;

  // The parse step runs whenever the input register holds an item and the
  // result register is free or being emptied in this cycle.
  assign s2_load = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s2_load;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_load) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s2_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_SEPARATOR: cfg_nxt.separator_char = cfg_ch.data;
        CFG_COMMENT:   cfg_nxt.comment_char = cfg_ch.data;
        CFG_QUOTE:     cfg_nxt.quote_char = cfg_ch.data;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  csvt_parser #(
    .LINE_COUNT_BITS(LINE_COUNT_BITS)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (s2_load),
    .in_byte      (s1_byte_r),
    .end_of_input (s1_eoi_r),
    .cfg          (cfg_r),
    .result       (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r.separator_char <= SEP_RESET;
      cfg_r.comment_char <= COMMENT_RESET;
      cfg_r.quote_char <= QUOTE_RESET;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_r <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_ch.in_byte;
      s1_eoi_r <= in_ch.end_of_input;
    end
    if (s2_load) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.out_byte = out_res_r.out_byte;
  assign out_ch.byte_valid = out_res_r.byte_valid;
  assign out_ch.field_end = out_res_r.field_end;
  assign out_ch.row_end = out_res_r.row_end;
  assign out_ch.error_code = out_res_r.error_code;
  assign out_ch.error_line = out_res_r.error_line;

`ifndef SYNTH
  // An error result abandons the row: no byte and no field or row mark.
  a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.error_code != ERR_NONE)) |->
      (!out_ch.byte_valid && !out_ch.field_end && !out_ch.row_end))
    else $error("error result carries a byte or an end mark");

  // The line number is reported only together with an error.
  a_line_only_on_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.error_code == ERR_NONE)) |-> (out_ch.error_line == '0))
    else $error("error_line set without an error");

  // A row end always closes the last field as well.
  a_row_closes_field: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.row_end) |-> out_ch.field_end)
    else $error("row_end without field_end");

  // A value byte never comes with an end mark.
  a_byte_no_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.byte_valid) |-> (!out_ch.field_end && !out_ch.row_end))
    else $error("value byte together with an end mark");
`endif

endmodule
